// ----- hdl/dcdow_pkg.sv -----
// Shared types, constants and lookup functions for the date check and weekday unit.
package dcdow_pkg;

  typedef struct packed {
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [13:0] year_in;
  } dcdow_in_t;

  typedef struct packed {
    logic       date_valid;
    logic [2:0] weekday;
  } dcdow_out_t;

  localparam logic [13:0] CutoverYear  = 14'd1752;
  localparam logic [3:0]  CutoverMonth = 4'd9;
  localparam logic [4:0]  CutoverDay   = 5'd14;

  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthMar = 4'd3;
  localparam logic [3:0] MonthApr = 4'd4;
  localparam logic [3:0] MonthMay = 4'd5;
  localparam logic [3:0] MonthJun = 4'd6;
  localparam logic [3:0] MonthJul = 4'd7;
  localparam logic [3:0] MonthAug = 4'd8;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthOct = 4'd10;
  localparam logic [3:0] MonthNov = 4'd11;
  localparam logic [3:0] MonthDec = 4'd12;

  // floor(y / 100) = (y * CentRecip) >> CentShift for 14-bit y
  localparam logic [12:0] CentRecip = 13'd5243;
  localparam int unsigned CentShift = 19;

  // floor(13 * (m + 1) / 5), January and February taken as months 13 and 14
  function automatic logic [5:0] month_term(input logic [3:0] month);
    logic [5:0] t;
    unique case (month)
      MonthJan: t = 6'd36;
      MonthFeb: t = 6'd39;
      MonthMar: t = 6'd10;
      MonthApr: t = 6'd13;
      MonthMay: t = 6'd15;
      MonthJun: t = 6'd18;
      MonthJul: t = 6'd20;
      MonthAug: t = 6'd23;
      MonthSep: t = 6'd26;
      MonthOct: t = 6'd28;
      MonthNov: t = 6'd31;
      MonthDec: t = 6'd33;
      default:  t = 6'd0;
    endcase
    return t;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] n;
    unique case (month)
      MonthFeb: n = leap ? 5'd29 : 5'd28;
      MonthApr, MonthJun, MonthSep, MonthNov: n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// ----- hdl/dcdow_core.sv -----
// Combinational date check and Zeller weekday for one date.
module dcdow_core (
  input  dcdow_pkg::dcdow_in_t  date_i,
  output dcdow_pkg::dcdow_out_t res_o
);

  logic [3:0]  month;
  logic [4:0]  day;
  logic [13:0] year;
  logic [26:0] cent_prod;
  logic [7:0]  cent;
  logic [13:0] hund;
  logic [6:0]  yoc;
  logic        leap;
  logic        early_month;
  logic [6:0]  yoc_a;
  logic [7:0]  cent_a;
  logic [10:0] sum;
  logic [4:0]  fold1;
  logic [3:0]  fold2;
  logic [2:0]  wday;
  logic        month_ok;
  logic        day_ok;
  logic        cutover_ok;

  assign month = date_i.month_in;
  assign day   = date_i.day_in;
  assign year  = date_i.year_in;

  // split the year into century and year of century
  assign cent_prod = 27'(year) * 27'(dcdow_pkg::CentRecip);
  assign cent      = cent_prod[26:dcdow_pkg::CentShift];
  assign hund      = {cent, 6'b0} + {1'b0, cent, 5'b0} + {4'b0, cent, 2'b0};
  assign yoc       = 7'(year - hund);

  assign leap = (year[1:0] == 2'b00) && ((yoc != 7'd0) || (cent[1:0] == 2'b00));

  // January and February belong to the previous year
  assign early_month = (month < dcdow_pkg::MonthMar);
  always_comb begin
    yoc_a  = yoc;
    cent_a = cent;
    if (early_month) begin
      if (yoc == 7'd0) begin
        yoc_a  = 7'd99;
        cent_a = cent - 8'd1;
      end else begin
        yoc_a = yoc - 7'd1;
      end
    end
  end

  assign sum = 11'(day) + 11'(dcdow_pkg::month_term(month)) + 11'(yoc_a)
             + 11'(yoc_a[6:2]) + 11'(cent_a[7:2]) + 11'({cent_a, 2'b0}) + 11'(cent_a);

  // reduce mod 7 by summing octal digits
  assign fold1 = 5'(sum[2:0]) + 5'(sum[5:3]) + 5'(sum[8:6]) + 5'(sum[10:9]);
  assign fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
  assign wday  = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

  assign month_ok = (month >= dcdow_pkg::MonthJan) && (month <= dcdow_pkg::MonthDec);
  assign day_ok   = (day != 5'd0) && (day <= dcdow_pkg::month_days(month, leap));
  assign cutover_ok = (year > dcdow_pkg::CutoverYear) ||
                      ((year == dcdow_pkg::CutoverYear) &&
                       ((month > dcdow_pkg::CutoverMonth) ||
                        ((month == dcdow_pkg::CutoverMonth) &&
                         (day >= dcdow_pkg::CutoverDay))));

  assign res_o.date_valid = month_ok && day_ok && cutover_ok;
  assign res_o.weekday    = res_o.date_valid ? wday : 3'd0;

endmodule

// ----- hdl/date_check_day_of_week_unit.sv -----
// Top level of the date check and weekday unit: input register, compute, result register.
// A date is held in the input register and its result in the result register, in that order;
// throughput: 1 date per cycle while the output is not stalled.
// The result register frees while the input register is refilled, so the unit stalls
// its input only when both stages hold data and the output is stalled.
// Reset clears both stage valid flags; payload registers are not reset.
module date_check_day_of_week_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  dcdow_pkg::dcdow_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output dcdow_pkg::dcdow_out_t out_data_o
);

  logic                  s1_valid_q;
  dcdow_pkg::dcdow_in_t  s1_data_q;
  logic                  out_valid_q;
  dcdow_pkg::dcdow_out_t out_data_q;
  dcdow_pkg::dcdow_out_t res_d;
  logic                  s1_adv;
  logic                  s2_adv;

  assign s2_adv     = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_stall_o = !s1_adv;

  dcdow_core u_core (
    .date_i (s1_data_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
    if (s2_adv && s1_valid_q) begin
      out_data_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.date_valid || (out_data_o.weekday == 3'd0)))
    else $error("invalid date with nonzero weekday");

  a_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.weekday != 3'd7))
    else $error("weekday out of range");

  a_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid_q)
    else $error("input transfer not captured");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled with room in the pipeline");

endmodule
